FILE: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared codes, command types and constants of the teletype engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_SETCUR = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // Control characters and the blank character.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Attribute after reset and the cell the store holds after reset.
  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [15:0] BLANK_RST  = {ATTR_RESET, CH_SPACE};

  // Register map of the configuration port.
  localparam logic REG_COLOR_ATTR = 1'b0;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_BS,
    OP_SETCUR,
    OP_CLEAR,
    OP_READ
  } op_e;

  // Column and row are already clamped to the screen.
  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_stat_t;

endpackage

FILE: hw/rtl/tcw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready channels for console items and their results.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic [7:0] col;
  logic [7:0] row;

  modport source (output valid, output kind, output char_code, output col, output row,
                  input ready);
  modport sink   (input valid, input kind, input char_code, input col, input row,
                  output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_pos;
  logic [15:0] cell_word;

  modport source (output valid, output cursor_pos, output cell_word, input ready);
  modport sink   (input valid, input cursor_pos, input cell_word, output ready);
endinterface

FILE: hw/rtl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Teletype engine over a character-cell text store with an APB register.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake            Beat contents
//  in_i      in   valid/ready          kind, char_code, col, row
//  out_o     out  valid/ready          cursor_pos, cell_word
//  APB       in   psel/penable/pready  color_attr at address 0
//
//  Characters, control codes and set cursor are carried out from ST_IDLE; a
//  cell read passes through ST_READ for the registered store read port.
//  Clear and a scroll walk the store one cell a cycle.
//  After reset all COLS*ROWS cells of the store (2000 at 80x25) are blanked
//  with in_i.ready low; configuration writes are taken meanwhile.
//  A two-beat queue lets the input run ahead while the back end or the
//  result register is stalled.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int TAB_STOP    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcw_in_if.sink      in_i,
  tcw_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] attr_q, attr_d;
  cmd_req_t   req;
  back_stat_t stat;

  assign pready = 1'b1;

  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && (paddr[2] == REG_COLOR_ATTR)) begin
      attr_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  assign prdata = (paddr[2] == REG_COLOR_ATTR) ? {24'h000000, attr_q} : 32'h0;

  tcw_front #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .stat_i(stat),
    .req_o (req)
  );

  tcw_back #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS),
    .TAB_STOP   (TAB_STOP)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .attr_i(attr_q),
    .req_i (req),
    .stat_o(stat),
    .out_o (out_o)
  );

endmodule

FILE: hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer RAM
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts items, decodes them into commands with clamped positions and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcw_in_if.sink     in_i,
  input  back_stat_t stat_i,
  output cmd_req_t   req_o
);

  cmd_t             cmd_in;
  cmd_t             queue_q [QDEPTH];
  logic [QPW-1:0]   wptr_q, wptr_d;
  logic [QPW-1:0]   rptr_q, rptr_d;
  logic [QCW-1:0]   count_q, count_d;
  logic             push;

  always_comb begin
    cmd_in.char_code = in_i.char_code;
    cmd_in.col = (in_i.col >= 8'(SCREEN_COLS)) ? 8'(SCREEN_COLS - 1) : in_i.col;
    cmd_in.row = (in_i.row >= 8'(SCREEN_ROWS)) ? 8'(SCREEN_ROWS - 1) : in_i.row;
    unique case (in_i.kind)
      KIND_PUT: begin
        unique case (in_i.char_code)
          CH_NL:   cmd_in.op = OP_NL;
          CH_CR:   cmd_in.op = OP_CR;
          CH_TAB:  cmd_in.op = OP_TAB;
          CH_BS:   cmd_in.op = OP_BS;
          default: cmd_in.op = OP_CHAR;
        endcase
      end
      KIND_SETCUR: cmd_in.op = OP_SETCUR;
      KIND_CLEAR:  cmd_in.op = OP_CLEAR;
      KIND_READ:   cmd_in.op = OP_READ;
      default:     cmd_in.op = OP_CHAR;
    endcase
  end

  // No item enters while the store is still being blanked after reset.
  assign in_i.ready = (count_q != QCW'(QDEPTH)) && !stat_i.init_busy;
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == QPW'(QDEPTH - 1)) ? '0 : QPW'(wptr_q + 1'b1);
    end
    if (stat_i.pop) begin
      rptr_d = (rptr_q == QPW'(QDEPTH - 1)) ? '0 : QPW'(rptr_q + 1'b1);
    end
    case ({push, stat_i.pop})
      2'b10:   count_d = QCW'(count_q + 1'b1);
      2'b01:   count_d = QCW'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= cmd_in;
    end
  end

  assign req_o.valid = (count_q != '0);
  assign req_o.cmd   = queue_q[rptr_q];

endmodule

FILE: hw/rtl/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer back end
// Carries out commands on the cursor and the text store: character writes,
// scroll copy, clear sweep and cell reads, and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int TAB_STOP    = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] attr_i,
  input  cmd_req_t   req_i,
  output back_stat_t stat_o,
  tcw_out_if.source  out_o
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int RW    = $clog2(SCREEN_ROWS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } state_e;

  state_e         state_q, state_d;
  logic [AW-1:0]  ptr_q, ptr_d;
  logic [RW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic           out_valid_q, out_valid_d;
  logic [10:0]    pos_q, pos_d;
  logic [15:0]    word_q, word_d;

  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata, rdata;
  logic [15:0]    blank;
  logic [15:0]    word_load;
  logic           pop, load, put_op, adv;
  logic [7:0]     nc;
  logic [AW:0]    src;
  logic [AW+10:0] pos_ext;
  logic [7:0]     tab_next [SCREEN_COLS];

  // Next tab stop for every column, worked out at elaboration.
  for (genvar g = 0; g < SCREEN_COLS; g++) begin : g_tab
    assign tab_next[g] = 8'(((g / TAB_STOP) + 1) * TAB_STOP);
  end

  function automatic logic [AW-1:0] lin_addr(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(SCREEN_COLS) + AW'(c));
  endfunction

  assign blank = {attr_i, CH_SPACE};
  assign src   = (AW+1)'(ptr_q) + (AW+1)'(SCREEN_COLS + 1);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    row_d       = row_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && !out_o.ready;
    pos_d       = pos_q;
    word_d      = word_q;
    we          = 1'b0;
    waddr       = ptr_q;
    wdata       = blank;
    re          = 1'b0;
    raddr       = AW'(SCREEN_COLS);
    pop         = 1'b0;
    load        = 1'b0;
    put_op      = 1'b0;
    adv         = 1'b0;
    nc          = 8'(col_q);
    word_load   = 16'h0000;

    unique case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        wdata = BLANK_RST;
        if (ptr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
          ptr_d   = '0;
        end else begin
          ptr_d = AW'(ptr_q + 1'b1);
        end
      end

      ST_IDLE: begin
        if (req_i.valid && (!out_valid_q || out_o.ready)) begin
          pop = 1'b1;
          unique case (req_i.cmd.op)
            OP_CHAR: begin
              put_op = 1'b1;
              we     = 1'b1;
              waddr  = lin_addr(row_q, col_q);
              wdata  = {attr_i, req_i.cmd.char_code};
              nc     = 8'(8'(col_q) + 8'd1);
            end
            OP_NL: begin
              put_op = 1'b1;
              nc     = 8'd0;
              adv    = 1'b1;
            end
            OP_CR: begin
              put_op = 1'b1;
              nc     = 8'd0;
            end
            OP_TAB: begin
              put_op = 1'b1;
              nc     = tab_next[col_q];
            end
            OP_BS: begin
              put_op = 1'b1;
              if (col_q != '0) begin
                nc    = 8'(8'(col_q) - 8'd1);
                we    = 1'b1;
                waddr = lin_addr(row_q, CW'(col_q - 1'b1));
              end
            end
            OP_SETCUR: begin
              col_d = CW'(req_i.cmd.col);
              row_d = RW'(req_i.cmd.row);
              load  = 1'b1;
            end
            OP_CLEAR: begin
              state_d = ST_CLEAR;
              ptr_d   = '0;
            end
            OP_READ: begin
              re      = 1'b1;
              raddr   = lin_addr(RW'(req_i.cmd.row), CW'(req_i.cmd.col));
              state_d = ST_READ;
            end
            default: ;
          endcase

          if (put_op) begin
            if (nc >= 8'(SCREEN_COLS)) begin
              nc  = 8'd0;
              adv = 1'b1;
            end
            col_d = CW'(nc);
            if (adv && (row_q == RW'(SCREEN_ROWS - 1))) begin
              // Start the scroll copy: the first source row is read now.
              state_d = ST_SCROLL;
              ptr_d   = '0;
              re      = 1'b1;
              raddr   = AW'(SCREEN_COLS);
            end else begin
              if (adv) begin
                row_d = RW'(row_q + 1'b1);
              end
              load = 1'b1;
            end
          end
        end
      end

      ST_READ: begin
        load      = 1'b1;
        word_load = rdata;
        state_d   = ST_IDLE;
      end

      ST_SCROLL: begin
        // Cell ptr takes the cell one row below, read in the previous cycle;
        // the bottom row is blanked.
        we    = 1'b1;
        waddr = ptr_q;
        wdata = (ptr_q < AW'(CELLS - SCREEN_COLS)) ? rdata : blank;
        if (src < (AW+1)'(CELLS)) begin
          re    = 1'b1;
          raddr = AW'(src);
        end
        if (ptr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
          ptr_d   = '0;
          load    = 1'b1;
        end else begin
          ptr_d = AW'(ptr_q + 1'b1);
        end
      end

      ST_CLEAR: begin
        we = 1'b1;
        if (ptr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
          ptr_d   = '0;
          row_d   = '0;
          col_d   = '0;
          load    = 1'b1;
        end else begin
          ptr_d = AW'(ptr_q + 1'b1);
        end
      end

      default: state_d = ST_IDLE;
    endcase

    pos_ext = (AW+11)'(lin_addr(row_d, col_d));
    if (load) begin
      out_valid_d = 1'b1;
      pos_d       = pos_ext[10:0];
      word_d      = word_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      word_q      <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      word_q      <= word_d;
    end
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign stat_o.pop       = pop;
  assign stat_o.init_busy = (state_q == ST_INIT);

  assign out_o.valid      = out_valid_q;
  assign out_o.cursor_pos = pos_q;
  assign out_o.cell_word  = word_q;

endmodule

FILE: hw/rtl/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level assertions on results, reset blanking and the register port.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] cursor_pos,
  input logic [15:0] cell_word,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic [2:0] open_q;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Items taken but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= 3'(open_q + {2'b00, in_beat} - {2'b00, out_beat});
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (open_q != 3'd0))
    else $error("result beat without an open item");

  a_blank_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready)
    else $error("input taken while the store is still being blanked");

  a_attr_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2])
      |=> (paddr[2] || (prdata[7:0] == $past(pwdata[7:0]))))
    else $error("color attribute does not read back as written");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(cursor_pos) && $stable(cell_word)))
    else $error("stalled result beat changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .cursor_pos(out_o.cursor_pos),
  .cell_word (out_o.cell_word),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

FILE: dv/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console items into the teletype engine and keeps a mirror of the
// 80x25 text store, the cursor and the color attribute. Every result beat
// is checked against the mirror. The color attribute is changed between
// phases over APB and read back. Both channels stall at random.
// ----------------------------------------------------------------------------
module text_console_writer_tb import tcw_pkg::*; ();

  localparam int SCREEN_COLS     = 80;
  localparam int SCREEN_ROWS     = 25;
  localparam int TAB_STOP        = 4;
  localparam int CELL_COUNT      = SCREEN_COLS * SCREEN_ROWS;
  localparam int QUIET_CYCLES    = CELL_COUNT + 100;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 215;
  localparam logic [2:0] COLOR_ATTR_ADDR = {REG_COLOR_ATTR, 2'b00};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [7:0] col;
    logic [7:0] row;
  } console_item_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_word;
  } console_result_t;

  // Mirror of the screen: predicts the result of each accepted item and
  // holds the results still due on the output channel.
  class screen_mirror;
    bit [15:0]       cells [CELL_COUNT];
    int unsigned     cur_row;
    int unsigned     cur_col;
    bit [7:0]        attr;
    console_result_t due_results [$];
    int unsigned     errors;
    int unsigned     results_seen;
    int unsigned     scrolls;
    int unsigned     kind_count [4];

    function new();
      attr = ATTR_RESET;
      clear_screen();
    endfunction

    function bit [15:0] blank();
      return {attr, CH_SPACE};
    endfunction

    function void clear_screen();
      foreach (cells[i]) cells[i] = blank();
      cur_row = 0;
      cur_col = 0;
    endfunction

    function void scroll_up();
      for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++) cells[i] = cells[i + SCREEN_COLS];
      for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++) cells[i] = blank();
      cur_row = SCREEN_ROWS - 1;
      scrolls++;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lim);
      return (v >= lim) ? lim - 1 : v;
    endfunction

    function void put_char(logic [7:0] c);
      case (c)
        CH_NL: begin
          cur_col = 0;
          cur_row++;
        end
        CH_CR: cur_col = 0;
        CH_TAB: cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
        CH_BS: begin
          if (cur_col > 0) begin
            cur_col--;
            cells[cur_row * SCREEN_COLS + cur_col] = blank();
          end
        end
        default: begin
          cells[cur_row * SCREEN_COLS + cur_col] = {attr, c};
          cur_col++;
        end
      endcase
      if (cur_col >= SCREEN_COLS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= SCREEN_ROWS) scroll_up();
    endfunction

    function void record_item(console_item_t it);
      console_result_t res;
      int unsigned     c;
      int unsigned     r;
      res.cell_word = '0;
      case (it.kind)
        KIND_PUT: put_char(it.char_code);
        KIND_SETCUR: begin
          cur_col = clamp(it.col, SCREEN_COLS);
          cur_row = clamp(it.row, SCREEN_ROWS);
        end
        KIND_CLEAR: clear_screen();
        default: begin
          // A read leaves the cursor where it is.
          c = clamp(it.col, SCREEN_COLS);
          r = clamp(it.row, SCREEN_ROWS);
          res.cell_word = cells[r * SCREEN_COLS + c];
        end
      endcase
      res.cursor_pos = 11'(cur_row * SCREEN_COLS + cur_col);
      kind_count[it.kind]++;
      due_results.push_back(res);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [10:0] cursor_pos, logic [15:0] cell_word);
      console_result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report($sformatf("result beat pos=%0d word=%h with nothing due", cursor_pos, cell_word));
      end else begin
        want = due_results.pop_front();
        if (cursor_pos !== want.cursor_pos) begin
          report($sformatf("beat %0d: cursor_pos %0d, want %0d",
                           results_seen, cursor_pos, want.cursor_pos));
        end
        if (cell_word !== want.cell_word) begin
          report($sformatf("beat %0d: cell_word %h, want %h",
                           results_seen, cell_word, want.cell_word));
        end
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  screen_mirror mirror = new();
  bit           steady_run;
  int unsigned  quiet_cycles;
  int unsigned  attr_writes;

  text_console_writer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Result side: random back-pressure, no stalls during the steady phase.
  always @(negedge clk_i) begin
    out_if.ready <= steady_run || ($urandom_range(99) >= 25);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      mirror.check_result(out_if.cursor_pos, out_if.cell_word);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ERROR @%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("text_console_writer_tb failed");
      $finish;
    end
  end

  function automatic console_item_t make_item(logic [1:0] kind, logic [7:0] char_code,
                                              logic [7:0] col, logic [7:0] row);
    console_item_t it;
    it.kind      = kind;
    it.char_code = char_code;
    it.col       = col;
    it.row       = row;
    return it;
  endfunction

  // Mostly text with control codes and cursor moves, some reads and clears,
  // and a share of fully random items.
  function automatic console_item_t random_item();
    console_item_t it;
    int unsigned   pick;
    it.kind      = KIND_PUT;
    it.char_code = 8'($urandom_range(8'h7E, 8'h20));
    it.col       = 8'($urandom);
    it.row       = 8'($urandom);
    pick         = $urandom_range(999);
    if (pick < 80) begin
      it.kind      = 2'($urandom);
      it.char_code = 8'($urandom);
    end else if (pick < 240) begin
      it.kind = (pick < 160) ? KIND_SETCUR : KIND_READ;
      if ($urandom_range(4) != 0) begin
        it.col = 8'($urandom_range(SCREEN_COLS - 1));
        it.row = ($urandom_range(3) == 0) ? 8'(SCREEN_ROWS - 1)
                                          : 8'($urandom_range(SCREEN_ROWS - 1));
      end
    end else if (pick < 255) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 310) begin
      it.char_code = CH_NL;
    end else if (pick < 330) begin
      it.char_code = CH_CR;
    end else if (pick < 370) begin
      it.char_code = CH_TAB;
    end else if (pick < 410) begin
      it.char_code = CH_BS;
    end else if (pick < 460) begin
      it.char_code = 8'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(console_item_t it);
    @(negedge clk_i);
    while (!steady_run && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= it.kind;
    in_if.char_code <= it.char_code;
    in_if.col       <= it.col;
    in_if.row       <= it.row;
    do @(posedge clk_i); while (!in_if.ready);
    mirror.record_item(it);
  endtask

  // Hold the input off until every result is back, then let a full store
  // walk finish so that no scroll or clear is still under way.
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_color_attr(logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COLOR_ATTR_ADDR;
    pwdata  <= {24'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mirror.attr = value;
    attr_writes++;
    // Read the register back in a second transfer.
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'b0, value}) begin
      mirror.report($sformatf("color_attr read %h, want %h", prdata, value));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    console_item_t directed [$];
    logic [7:0]    attr_value;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_PUT;
    in_if.char_code = '0;
    in_if.col       = '0;
    in_if.row       = '0;
    out_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed = '{
      make_item(KIND_READ, 8'h00, 8'd0, 8'd0),
      make_item(KIND_READ, 8'h00, 8'd255, 8'd255),
      make_item(KIND_PUT, 8'h41, 8'd0, 8'd0),
      make_item(KIND_PUT, 8'h00, 8'd0, 8'd0),
      make_item(KIND_PUT, 8'hFF, 8'd0, 8'd0),
      make_item(KIND_PUT, CH_TAB, 8'd0, 8'd0),
      make_item(KIND_PUT, CH_TAB, 8'd0, 8'd0),
      make_item(KIND_PUT, CH_BS, 8'd0, 8'd0),
      make_item(KIND_READ, 8'h00, 8'd7, 8'd0),
      make_item(KIND_PUT, CH_CR, 8'd0, 8'd0),
      make_item(KIND_PUT, CH_BS, 8'd0, 8'd0),
      make_item(KIND_SETCUR, 8'h00, 8'd255, 8'd255),
      make_item(KIND_PUT, 8'h5A, 8'd0, 8'd0),
      make_item(KIND_READ, 8'h00, 8'(SCREEN_COLS - 1), 8'(SCREEN_ROWS - 2)),
      make_item(KIND_SETCUR, 8'h00, 8'(SCREEN_COLS - 2), 8'(SCREEN_ROWS - 1)),
      make_item(KIND_PUT, CH_TAB, 8'd0, 8'd0),
      make_item(KIND_SETCUR, 8'h00, 8'(SCREEN_COLS), 8'(SCREEN_ROWS)),
      make_item(KIND_PUT, CH_NL, 8'd0, 8'd0),
      make_item(KIND_READ, 8'h00, 8'd0, 8'd0),
      make_item(KIND_CLEAR, 8'h00, 8'd0, 8'd0),
      make_item(KIND_READ, 8'h00, 8'(SCREEN_COLS - 1), 8'(SCREEN_ROWS - 1)),
      make_item(KIND_PUT, CH_NL, 8'd0, 8'd0),
      make_item(KIND_SETCUR, 8'h00, 8'd0, 8'd0),
      make_item(KIND_PUT, 8'h7F, 8'd0, 8'd0)
    };
    foreach (directed[i]) send_item(directed[i]);
    settle();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       attr_value = 8'h00;
        1:       attr_value = 8'hFF;
        default: attr_value = 8'($urandom);
      endcase
      set_color_attr(attr_value);
      steady_run = (phase == 2);
      repeat (ITEMS_PER_PHASE) send_item(random_item());
      steady_run = 1'b0;
      settle();
    end

    if (mirror.due_results.size() != 0) begin
      mirror.report($sformatf("%0d results never arrived", mirror.due_results.size()));
    end
    $display("Covered %0d puts, %0d cursor moves, %0d clears and %0d reads; %0d beats checked.",
             mirror.kind_count[KIND_PUT], mirror.kind_count[KIND_SETCUR],
             mirror.kind_count[KIND_CLEAR], mirror.kind_count[KIND_READ], mirror.results_seen);
    $display("The screen scrolled %0d times under %0d color settings; %0d mismatches.",
             mirror.scrolls, attr_writes + 1, mirror.errors);
    if (mirror.errors == 0) begin
      $display("text_console_writer_tb passed");
    end else begin
      $display("text_console_writer_tb failed");
    end
    $finish;
  end

endmodule
